>>> design/route_forward_decision_assert.svh
// Assertion macros used by the route lookup top level.
`ifndef ROUTE_FORWARD_DECISION_ASSERT_SVH
`define ROUTE_FORWARD_DECISION_ASSERT_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define RFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define RFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/rfd_pkg.sv
// Types and constants of the route forwarding lookup.
package rfd_pkg;

    localparam int CFG_DW = 32;

    localparam logic       OP_WRITE      = 1'b0;
    localparam logic       OP_ROUTE      = 1'b1;

    localparam logic       CFG_OWN_ADDR  = 1'b0;
    localparam logic       CFG_UDP_PROTO = 1'b1;

    localparam logic [2:0] ACT_WRITE     = 3'd0;
    localparam logic [2:0] ACT_DROP      = 3'd1;
    localparam logic [2:0] ACT_GATEWAY   = 3'd2;
    localparam logic [2:0] ACT_DIRECT    = 3'd3;
    localparam logic [2:0] ACT_LOCAL     = 3'd4;

    localparam int FLAG_UP_BIT = 0;
    localparam int FLAG_GW_BIT = 1;

    // RIP multicast group 224.0.0.9
    localparam logic [31:0] MULTICAST_RIP = {8'hE0, 8'h00, 8'h00, 8'h09};
    localparam logic [7:0]  UDP_PROTO_RST = 8'd17;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] network;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [7:0]  port;
        logic [1:0]  flags;
    } t_entry;

    typedef struct packed {
        logic        hit;
        logic [2:0]  action;
        logic [31:0] next_hop;
        logic [7:0]  port;
    } t_match;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] next_hop;
        logic [7:0]  port;
        logic [3:0]  idx;
    } t_result;

endpackage

>>> design/rfd_in_if.sv
// Input channel: table writes and route requests.
interface rfd_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_network;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [7:0]  entry_port;
    logic [1:0]  entry_flags;
    logic [31:0] packet_source;
    logic [31:0] packet_destination;
    logic [7:0]  packet_protocol;

    modport source (
        output valid, operation, entry_index, entry_valid, entry_network, entry_mask,
               entry_gateway, entry_port, entry_flags, packet_source,
               packet_destination, packet_protocol,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, entry_valid, entry_network, entry_mask,
               entry_gateway, entry_port, entry_flags, packet_source,
               packet_destination, packet_protocol,
        output ready
    );
endinterface

>>> design/rfd_out_if.sv
// Output channel: forwarding decisions.
interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] next_hop;
    logic [7:0]  out_port;
    logic [3:0]  matched_index;

    modport source (
        output valid, action, next_hop, out_port, matched_index,
        input  ready
    );
    modport sink (
        input  valid, action, next_hop, out_port, matched_index,
        output ready
    );
endinterface

>>> design/rfd_ram.sv
// Generic single-port-write, registered-read RAM.
module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rfd_match.sv
// Shared compare unit: tests one table entry against the destination.
module rfd_match import rfd_pkg::*; (
    input  t_entry      i_entry,
    input  logic        i_valid,
    input  logic [31:0] i_dst,
    output t_match      o_res
);

    always_comb begin
        o_res.hit  = i_valid && (i_entry.network == (i_dst & i_entry.mask));
        o_res.port = i_entry.port;
        if (i_entry.flags[FLAG_GW_BIT]) begin
            o_res.action   = ACT_GATEWAY;
            o_res.next_hop = i_entry.gateway;
        end else if (i_entry.flags[FLAG_UP_BIT]) begin
            o_res.action   = ACT_DIRECT;
            o_res.next_hop = i_dst;
        end else begin
            o_res.action   = ACT_DROP;
            o_res.next_hop = '0;
        end
    end

endmodule

>>> design/route_forward_decision.sv
// Route forwarding decision: first-match routing table lookup, top level.
//
// Input channel i_in carries either a table write (operation 0) or a route
// request (operation 1); output channel o_out returns one decision per
// transaction. Both use valid/ready; a transaction moves when both are high.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 own address, 1 UDP protocol number); write only while idle.
// A table write goes from acceptance straight to the result state and from
// there into the output register. A route request scans the table one entry
// per cycle through a single RAM read port and one compare unit; it finishes
// early on the first matching entry. A request from the own address (not to
// 224.0.0.9) is dropped without a scan. One transaction is
// in flight at a time; i_in.ready is high only while the sequencer idles.
// A finished result sits in the output register while the receiver stalls;
// the next transaction is already accepted and worked on meanwhile.
// Reset marks every table entry invalid at once (valid flags in flops),
// sets own address to 0 and the UDP protocol to 17.
module route_forward_decision import rfd_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rfd_in_if.sink            i_in,
    rfd_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

`include "route_forward_decision_assert.svh"

    localparam int            AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST     = AW'(TABLE_DEPTH - 1);
    localparam logic [8:0]    DEPTH_W9 = 9'(TABLE_DEPTH);

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_chk_idx;
    logic          r_chk_vld;
    logic [31:0]   r_dst, n_dst;
    logic [7:0]    r_proto, n_proto;
    t_result       r_res, n_res;
    t_result       r_out;
    logic          r_out_valid;
    logic          out_load;
    logic [31:0]   r_own_addr;
    logic [7:0]    r_udp_proto;
    logic          r_valid [TABLE_DEPTH];

    logic          in_acc;
    logic          idx_ok;
    logic          tbl_we;
    logic [AW-1:0] waddr;
    t_entry        wentry;
    t_entry        rentry;
    t_match        m;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign idx_ok     = 9'(i_in.entry_index) < DEPTH_W9;
    assign waddr      = AW'(i_in.entry_index);
    assign tbl_we     = in_acc && (i_in.operation == OP_WRITE) && idx_ok;

    assign wentry.network = i_in.entry_network;
    assign wentry.mask    = i_in.entry_mask;
    assign wentry.gateway = i_in.entry_gateway;
    assign wentry.port    = i_in.entry_port;
    assign wentry.flags   = i_in.entry_flags;

    rfd_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we && i_in.entry_valid),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (r_addr),
        .o_rdata (rentry)
    );

    rfd_match u_match (
        .i_entry (rentry),
        .i_valid (r_chk_vld),
        .i_dst   (r_dst),
        .o_res   (m)
    );

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_pend   = r_pend;
        n_dst    = r_dst;
        n_proto  = r_proto;
        n_res    = r_res;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res   = '{action: ACT_WRITE, next_hop: '0, port: '0, idx: '0};
                    n_dst   = i_in.packet_destination;
                    n_proto = i_in.packet_protocol;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_state = ST_EMIT;
                    if (i_in.operation == OP_ROUTE) begin
                        if (i_in.packet_source == r_own_addr &&
                            i_in.packet_destination != MULTICAST_RIP) begin
                            n_res.action = ACT_DROP;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend && m.hit) begin
                    n_res   = '{action: m.action, next_hop: m.next_hop,
                                port: m.port, idx: 4'(r_chk_idx)};
                    n_pend  = 1'b0;
                    n_state = ST_EMIT;
                end else if (r_pend && r_chk_idx == LAST) begin
                    // table exhausted without a match
                    n_res   = '{action: (r_proto == r_udp_proto) ? ACT_LOCAL : ACT_DROP,
                                next_hop: '0, port: '0, idx: '0};
                    n_pend  = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_pend = 1'b1;
                    if (r_addr != LAST) begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_own_addr  <= '0;
            r_udp_proto <= UDP_PROTO_RST;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OWN_ADDR:  r_own_addr  <= i_cfg_data;
                    CFG_UDP_PROTO: r_udp_proto <= i_cfg_data[7:0];
                    default:       r_own_addr  <= r_own_addr;
                endcase
            end
            if (tbl_we) begin
                // clearing drops the valid flag only; entry data stays
                r_valid[waddr] <= i_in.entry_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst     <= n_dst;
        r_proto   <= n_proto;
        r_res     <= n_res;
        r_chk_idx <= r_addr;
        r_chk_vld <= r_valid[r_addr];
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_out.action;
    assign o_out.next_hop      = r_out.next_hop;
    assign o_out.out_port      = r_out.port;
    assign o_out.matched_index = r_out.idx;

    `RFD_ASSERT(a_write_to_emit, i_clk, i_rst_n, in_acc && i_in.operation == OP_WRITE |=> r_state == ST_EMIT, "table write did not go straight to result")
    `RFD_ASSERT(a_scan_addr_range, i_clk, i_rst_n, r_state == ST_SCAN |-> r_addr <= LAST, "scan address beyond table")
    `RFD_ASSERT(a_emit_loads_out, i_clk, i_rst_n, out_load |=> r_out_valid && r_state == ST_IDLE, "result not loaded into output register")
    `RFD_ASSERT_ALWAYS(a_pend_in_scan, i_clk, r_pend |-> r_state == ST_SCAN, "compare pending outside scan")

endmodule

>>> tb/sv/route_forward_decision_tb.sv
// Testbench of route_forward_decision: directed table, random phases, self-checking.
module route_forward_decision_tb import rfd_pkg::*;;

    localparam int TBL_DEPTH   = 16;
    localparam int SETTLE_CYC  = 25;      // longest scan plus margin
    localparam int HOLDOFF_CYC = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 115;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot;
        logic        store;
        logic [31:0] network;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [7:0]  port;
        logic [1:0]  flags;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
    } t_route_req;

    typedef struct {
        t_route_req req;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    rfd_in_if  in_ch();
    rfd_out_if out_ch();

    route_forward_decision #(.TABLE_DEPTH(TBL_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the routing table and registers
    logic        tbl_valid   [TBL_DEPTH];
    logic [31:0] tbl_network [TBL_DEPTH];
    logic [31:0] tbl_mask    [TBL_DEPTH];
    logic [31:0] tbl_gateway [TBL_DEPTH];
    logic [7:0]  tbl_port    [TBL_DEPTH];
    logic [1:0]  tbl_flags   [TBL_DEPTH];
    bit          slot_loaded [TBL_DEPTH];
    logic [31:0] own_addr_m;
    logic [7:0]  udp_proto_m;

    t_result pending_decisions[$];
    int      errors;
    int      act_seen[5];
    int      cycles;
    int      holdoff_req;
    int      holdoff_seen;
    int      holdoff_left;
    int      rx_mode;
    int      mode_left;
    int      rx_tick;

    function automatic t_result decision(logic [2:0] act, logic [31:0] hop,
                                         logic [7:0] port, logic [3:0] idx);
        t_result d;
        d.action   = act;
        d.next_hop = hop;
        d.port     = port;
        d.idx      = idx;
        return d;
    endfunction

    function automatic t_route_req mk_write(logic [3:0] slot, logic store,
                                            logic [31:0] network, logic [31:0] mask,
                                            logic [31:0] gateway, logic [7:0] port,
                                            logic [1:0] flags);
        t_route_req r;
        r         = '0;
        r.op      = OP_WRITE;
        r.slot    = slot;
        r.store   = store;
        r.network = network;
        r.mask    = mask;
        r.gateway = gateway;
        r.port    = port;
        r.flags   = flags;
        return r;
    endfunction

    function automatic t_route_req mk_route(logic [31:0] src, logic [31:0] dst,
                                            logic [7:0] proto);
        t_route_req r;
        r       = '1;
        r.op    = OP_ROUTE;
        r.src   = src;
        r.dst   = dst;
        r.proto = proto;
        return r;
    endfunction

    // Applies one transaction to the shadow table and returns the decision.
    function automatic t_result apply_request(t_route_req r);
        t_result d;
        d = '0;
        if (r.op == OP_WRITE) begin
            if (int'(r.slot) < TBL_DEPTH) begin
                if (r.store) begin
                    tbl_network[r.slot] = r.network;
                    tbl_mask[r.slot]    = r.mask;
                    tbl_gateway[r.slot] = r.gateway;
                    tbl_port[r.slot]    = r.port;
                    tbl_flags[r.slot]   = r.flags;
                    tbl_valid[r.slot]   = 1'b1;
                    slot_loaded[r.slot] = 1'b1;
                end else begin
                    tbl_valid[r.slot] = 1'b0;
                end
            end
            d.action = ACT_WRITE;
            return d;
        end
        if (r.src == own_addr_m && r.dst != MULTICAST_RIP) begin
            d.action = ACT_DROP;
            return d;
        end
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i] && tbl_network[i] == (r.dst & tbl_mask[i])) begin
                d.port = tbl_port[i];
                d.idx  = i[3:0];
                if (tbl_flags[i][FLAG_GW_BIT]) begin
                    d.action   = ACT_GATEWAY;
                    d.next_hop = tbl_gateway[i];
                end else if (tbl_flags[i][FLAG_UP_BIT]) begin
                    d.action   = ACT_DIRECT;
                    d.next_hop = r.dst;
                end else begin
                    d.action = ACT_DROP;
                end
                return d;
            end
        end
        d.action = (r.proto == udp_proto_m) ? ACT_LOCAL : ACT_DROP;
        return d;
    endfunction

    // Mostly prefix routes and destinations aimed at loaded slots.
    function automatic t_route_req rand_req();
        t_route_req r;
        int         plen;
        int         k;
        r.op      = ($urandom_range(99) < 35) ? OP_WRITE : OP_ROUTE;
        r.slot    = 4'($urandom);
        r.store   = ($urandom_range(9) < 8);
        r.gateway = $urandom;
        r.port    = 8'($urandom);
        r.flags   = 2'($urandom);
        r.src     = $urandom;
        r.dst     = $urandom;
        r.proto   = 8'($urandom);
        plen      = $urandom_range(32);
        r.mask    = 32'hFFFF_FFFF << (32 - plen);
        if ($urandom_range(9) == 0)
            r.mask = $urandom;
        r.network = $urandom;
        if ($urandom_range(9) != 0)
            r.network = r.network & r.mask;
        if (r.op == OP_ROUTE) begin
            k = $urandom_range(TBL_DEPTH - 1);
            if (slot_loaded[k] && $urandom_range(9) < 7)
                r.dst = (tbl_network[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
            else if ($urandom_range(11) == 0)
                r.dst = MULTICAST_RIP;
            if ($urandom_range(9) == 0)
                r.src = own_addr_m;
            if ($urandom_range(9) < 4)
                r.proto = udp_proto_m;
        end
        return r;
    endfunction

    task automatic send_req(input t_route_req r, input bit typed, input t_result want);
        t_result d;
        in_ch.valid              <= 1'b1;
        in_ch.operation          <= r.op;
        in_ch.entry_index        <= r.slot;
        in_ch.entry_valid        <= r.store;
        in_ch.entry_network      <= r.network;
        in_ch.entry_mask         <= r.mask;
        in_ch.entry_gateway      <= r.gateway;
        in_ch.entry_port         <= r.port;
        in_ch.entry_flags        <= r.flags;
        in_ch.packet_source      <= r.src;
        in_ch.packet_destination <= r.dst;
        in_ch.packet_protocol    <= r.proto;
        do @(posedge i_clk); while (!in_ch.ready);
        d = apply_request(r);
        pending_decisions.push_back(typed ? want : d);
    endtask

    // Burst pacing: a random gap opens each new burst.
    task automatic pace(inout int burst_left, input int max_gap);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap        = $urandom_range(max_gap);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [31:0] own, input logic [7:0] udp);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OWN_ADDR;
        i_cfg_data  <= own;
        @(posedge i_clk);
        i_cfg_index <= CFG_UDP_PROTO;
        i_cfg_data  <= {24'd0, udp};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        own_addr_m  = own;
        udp_proto_m = udp;
    endtask

    // receiver: ready pattern changes mode now and then; long hold-off on request
    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_req) begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYC;
        end
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(3);
            mode_left = $urandom_range(256, 64);
        end else begin
            mode_left--;
        end
        rx_tick++;
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(99) >= 30);
                2: out_ch.ready <= ($urandom_range(99) >= 75);
                default: out_ch.ready <= ((rx_tick % 7) >= 3);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        string   got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_decisions.size() == 0) begin
                errors++;
                $display("%0t: unexpected decision act=%0d hop=%h port=%h idx=%0d", $time,
                         out_ch.action, out_ch.next_hop, out_ch.out_port,
                         out_ch.matched_index);
            end else begin
                want = pending_decisions.pop_front();
                if (out_ch.action !== want.action || out_ch.next_hop !== want.next_hop ||
                    out_ch.out_port !== want.port || out_ch.matched_index !== want.idx) begin
                    errors++;
                    got = $sformatf("act=%0d hop=%h port=%h idx=%0d", out_ch.action,
                                    out_ch.next_hop, out_ch.out_port,
                                    out_ch.matched_index);
                    $display("%0t: mismatch expected act=%0d hop=%h port=%h idx=%0d, got %s",
                             $time, want.action, want.next_hop, want.port, want.idx, got);
                end
                if (want.action <= ACT_LOCAL)
                    act_seen[want.action]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d decisions outstanding", $time,
                     pending_decisions.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_dir_row    dir_rows[$];
        logic [31:0] own_set[NUM_PHASES];
        logic [7:0]  udp_set[NUM_PHASES];
        int          gap_set[NUM_PHASES];
        int          burst_left;
        t_result     none;

        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_index              = CFG_OWN_ADDR;
        i_cfg_data               = '0;
        in_ch.valid              = 1'b0;
        in_ch.operation          = OP_WRITE;
        in_ch.entry_index        = '0;
        in_ch.entry_valid        = 1'b0;
        in_ch.entry_network      = '0;
        in_ch.entry_mask         = '0;
        in_ch.entry_gateway      = '0;
        in_ch.entry_port         = '0;
        in_ch.entry_flags        = '0;
        in_ch.packet_source      = '0;
        in_ch.packet_destination = '0;
        in_ch.packet_protocol    = '0;
        out_ch.ready             = 1'b0;
        errors                   = 0;
        cycles                   = 0;
        holdoff_req              = 0;
        holdoff_seen             = 0;
        holdoff_left             = 0;
        mode_left                = 0;
        rx_tick                  = 0;
        burst_left               = 0;
        own_addr_m               = '0;
        udp_proto_m              = UDP_PROTO_RST;
        none                     = decision(ACT_WRITE, '0, '0, '0);
        foreach (act_seen[a]) act_seen[a] = 0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_valid[i]   = 1'b0;
            slot_loaded[i] = 1'b0;
        end

        // directed: reset state, extremes, every action, clear and re-store
        dir_rows.push_back('{mk_route(32'd0, 32'h0102_0304, 8'd17), 1'b1,
                             decision(ACT_DROP, '0, '0, '0)});
        dir_rows.push_back('{mk_route(32'd0, MULTICAST_RIP, 8'd17), 1'b1,
                             decision(ACT_LOCAL, '0, '0, '0)});
        dir_rows.push_back('{mk_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF), 1'b1,
                             decision(ACT_DROP, '0, '0, '0)});
        dir_rows.push_back('{mk_route(32'd1, 32'd0, 8'd0), 1'b1,
                             decision(ACT_DROP, '0, '0, '0)});
        dir_rows.push_back('{mk_write(4'd0, 1'b1, 32'h0A00_0000, 32'hFF00_0000,
                                      32'hC0A8_0001, 8'hFF, 2'b10), 1'b1, none});
        dir_rows.push_back('{mk_route(32'd5, 32'h0A12_3456, 8'd6), 1'b1,
                             decision(ACT_GATEWAY, 32'hC0A8_0001, 8'hFF, 4'd0)});
        dir_rows.push_back('{mk_write(4'd15, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF,
                                      8'h00, 2'b01), 1'b1, none});
        dir_rows.push_back('{mk_route(32'd5, 32'h0B00_0001, 8'd6), 1'b1,
                             decision(ACT_DIRECT, 32'h0B00_0001, 8'h00, 4'd15)});
        dir_rows.push_back('{mk_write(4'd3, 1'b1, 32'h0B00_0000, 32'hFF00_0000,
                                      32'd0, 8'h55, 2'b00), 1'b1, none});
        // matched entry without flags drops but reports the entry
        dir_rows.push_back('{mk_route(32'd5, 32'h0B00_0001, 8'd17), 1'b1,
                             decision(ACT_DROP, '0, 8'h55, 4'd3)});
        dir_rows.push_back('{mk_write(4'd3, 1'b1, 32'h0B00_0000, 32'hFF00_0000,
                                      32'h0B00_00FE, 8'hAA, 2'b11), 1'b1, none});
        dir_rows.push_back('{mk_route(32'd5, 32'h0B00_0002, 8'd6), 1'b0, none});
        // clearing keeps the other fields; write payload is ignored
        dir_rows.push_back('{mk_write(4'd3, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 8'hFF, 2'b11), 1'b1, none});
        dir_rows.push_back('{mk_route(32'd5, 32'h0B00_0002, 8'd6), 1'b0, none});
        dir_rows.push_back('{mk_write(4'd8, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'h1234_5678, 8'h01, 2'b10), 1'b1, none});
        dir_rows.push_back('{mk_route(32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'hFF), 1'b0, none});
        dir_rows.push_back('{mk_write(4'd0, 1'b0, '0, '0, '0, '0, '0), 1'b1, none});
        dir_rows.push_back('{mk_write(4'd15, 1'b0, '0, '0, '0, '0, '0), 1'b1, none});
        dir_rows.push_back('{mk_write(4'd8, 1'b0, '0, '0, '0, '0, '0), 1'b1, none});
        dir_rows.push_back('{mk_route(32'd0, MULTICAST_RIP, 8'd17), 1'b1,
                             decision(ACT_LOCAL, '0, '0, '0)});
        dir_rows.push_back('{mk_route(32'd0, 32'h0A00_0001, 8'd17), 1'b1,
                             decision(ACT_DROP, '0, '0, '0)});
        dir_rows.push_back('{mk_write(4'd3, 1'b1, 32'h0B00_0000, 32'hFF00_0000,
                                      32'h0000_0001, 8'h07, 2'b01), 1'b1, none});
        dir_rows.push_back('{mk_route(32'd9, 32'h0B00_00FF, 8'd1), 1'b0, none});

        own_set = '{32'hFFFF_FFFF, $urandom, 32'd0, MULTICAST_RIP, $urandom, 32'h0A00_0001};
        udp_set = '{8'd0, 8'hFF, UDP_PROTO_RST, 8'($urandom), 8'd6, UDP_PROTO_RST};
        gap_set = '{5, 6, 0, 8, 0, 3};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            pace(burst_left, 3);
            send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);
        end
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_config(own_set[p], udp_set[p]);
            burst_left = 0;
            // stall the output while the input keeps offering transactions
            if (p == 2)
                holdoff_req++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pace(burst_left, gap_set[p]);
                send_req(rand_req(), 1'b0, none);
            end
            wait_idle();
        end

        $display("checked %0d writes, %0d drops, %0d via gateway, %0d direct, %0d local",
                 act_seen[ACT_WRITE], act_seen[ACT_DROP], act_seen[ACT_GATEWAY],
                 act_seen[ACT_DIRECT], act_seen[ACT_LOCAL]);
        $display("%0d register settings, one long output hold-off, %0d cycles",
                 NUM_PHASES + 1, cycles);
        if (errors == 0 && pending_decisions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/rfd_pkg.sv
design/rfd_in_if.sv
design/rfd_out_if.sv
design/rfd_ram.sv
design/rfd_match.sv
design/route_forward_decision.sv
tb/sv/route_forward_decision_tb.sv
